// File: src/q2e_pkg.sv
// shared constants and the cordic arctangent table for the quaternion to euler block
// no dependencies
`default_nettype none
package q2e_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF  = 16;

    localparam int INT_Q    = 28;
    localparam int ANG_W    = 20;
    localparam int SQ_STEPS = INT_Q + 1;
    localparam int SQ_W     = 2 * INT_Q + 2;
    localparam int TOL_W    = 21;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2684);

    localparam logic signed [ANG_W-1:0] PI_Q16      = ANG_W'(205887);
    localparam logic signed [13:0]      HALF_PI_Q12 = 14'sd6434;
    localparam int BANK_MAX = 12868;
    localparam int ATT_MAX  = 6434;
    localparam int HEAD_MAX = 25736;

    localparam logic [1:0] PC_GENERAL = 2'd0;
    localparam logic [1:0] PC_NORTH   = 2'd1;
    localparam logic [1:0] PC_SOUTH   = 2'd2;

    // atan(2^-i) in q16 radians
    function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
        logic signed [ANG_W-1:0] a;
        unique case (i)
            0:       a = ANG_W'(51472);
            1:       a = ANG_W'(30386);
            2:       a = ANG_W'(16055);
            3:       a = ANG_W'(8150);
            4:       a = ANG_W'(4091);
            5:       a = ANG_W'(2047);
            6:       a = ANG_W'(1024);
            7:       a = ANG_W'(512);
            8:       a = ANG_W'(256);
            9:       a = ANG_W'(128);
            10:      a = ANG_W'(64);
            11:      a = ANG_W'(32);
            12:      a = ANG_W'(16);
            13:      a = ANG_W'(8);
            14:      a = ANG_W'(4);
            15:      a = ANG_W'(2);
            16:      a = ANG_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: src/q2e_sqrt_cell.sv
// one digit step of the integer square root chain
// depends on q2e_pkg
`default_nettype none
module q2e_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [q2e_pkg::SQ_W-1:0] rem_in,
    input  wire logic [q2e_pkg::SQ_W-1:0] root_in,
    output logic      [q2e_pkg::SQ_W-1:0] rem_out,
    output logic      [q2e_pkg::SQ_W-1:0] root_out
);
    import q2e_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * STEP);

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] rem_next;
    logic [SQ_W-1:0] root_next;

    always_comb
    begin
        trial = root_in + BIT;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            root_out <= root_next;
        end
    end

endmodule
`default_nettype wire

// File: src/q2e_cordic_cell.sv
// one vectoring micro-rotation of a cordic chain
// depends on q2e_pkg
`default_nettype none
module q2e_cordic_cell #(
    parameter int DW    = 38,
    parameter int SHIFT = 0
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [DW-1:0]             x_in,
    input  wire logic signed [DW-1:0]             y_in,
    input  wire logic signed [q2e_pkg::ANG_W-1:0] ang_in,
    output logic      signed [DW-1:0]             x_out,
    output logic      signed [DW-1:0]             y_out,
    output logic      signed [q2e_pkg::ANG_W-1:0] ang_out
);
    import q2e_pkg::*;

    localparam logic signed [ANG_W-1:0] STEP_ANG = atan_q16(SHIFT);

    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;

    assign xs = x_in >>> SHIFT;
    assign ys = y_in >>> SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[DW-1])
            begin
                x_out   <= x_in + ys;
                y_out   <= y_in - xs;
                ang_out <= ang_in + STEP_ANG;
            end
            else
            begin
                x_out   <= x_in - ys;
                y_out   <= y_in + xs;
                ang_out <= ang_in - STEP_ANG;
            end
        end
    end

endmodule
`default_nettype wire

// File: src/quaternion_to_euler_angles.sv
// quaternion to euler angle converter, top level
// depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic_cell
//
// usage
//   s_axis carries one quaternion word: tdata holds w, x, y, z (16 bits each,
//   signed q1.14). m_axis returns one word per quaternion: tdata holds bank,
//   attitude, heading (q2.12, q1.12, q3.12 radians), tuser holds the pole case
// throughput: one word per cycle unless m_axis stalls, every stage is a chain register
// stages, in order:
//   products, pole test and sums, square of the sine, 29 square root digit
//   cells, quadrant fold, the cordic cells, rounding and saturation
// stalls: each stage holds its word while the next one is full and held, so
//   bubbles close up; while a finished word waits at m_axis, empty stages take new words
// reset: the chain empties and pole_tolerance returns to 2684
// cfg_wr_en/cfg_wr_data write pole_tolerance; write only while the chain is
//   empty
`default_nettype none
module quaternion_to_euler_angles #(
    parameter int QUAT_FRAC_BITS = q2e_pkg::QUAT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES  = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [q2e_pkg::TOL_W-1:0]  cfg_wr_data,    // pole_tolerance
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [63:0]                s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [47:0]                m_axis_tdata,   // bank_angle, attitude_angle,
                                                            // heading_angle, zero pad
    output logic      [1:0]                 m_axis_tuser    // pole_case
);
    import q2e_pkg::*;

    // scale of the product sums relative to q28
    localparam int SH  = 2 * QUAT_FRAC_BITS - INT_Q;
    localparam int RSH = (SH > 0) ? SH : 0;
    localparam int LSH = (SH < 0) ? -SH : 0;
    localparam int QW  = 36 + LSH;
    localparam int CW  = QW + 2;

    // stage map
    localparam int ST_SQ  = 3;
    localparam int ST_PRE = ST_SQ + SQ_STEPS;
    localparam int ST_COR = ST_PRE + 1;
    localparam int ST_OUT = ST_COR + CORDIC_STAGES;
    localparam int NST    = ST_OUT + 1;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } rot_t;

    function automatic logic signed [QW-1:0] to_q28(input logic signed [QW-1:0] v);
        return (v >>> RSH) <<< LSH;
    endfunction

    // quadrant fold ahead of the cordic chain
    function automatic rot_t prerot(input logic signed [CW-1:0] y,
                                    input logic signed [CW-1:0] x);
        rot_t r;
        r.zero = (x == '0) && (y == '0);
        if (x[CW-1])
        begin
            r.ang = y[CW-1] ? -PI_Q16 : PI_Q16;
            r.x   = -x;
            r.y   = -y;
        end
        else
        begin
            r.ang = '0;
            r.x   = x;
            r.y   = y;
        end
        return r;
    endfunction

    // q16 to q12 with round half up, then clamp
    function automatic logic signed [15:0] to_q12_sat(input logic signed [ANG_W+1:0] a,
                                                      input int lim);
        logic signed [ANG_W+1:0] r;
        logic signed [ANG_W+1:0] l;
        r = (a + (ANG_W+2)'(8)) >>> 4;
        l = (ANG_W+2)'(lim);
        if (r > l)
            return 16'(l);
        else if (r < -l)
            return 16'(-l);
        else
            return 16'(r);
    endfunction

    // ---------------- handshake: one valid bit per stage
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || m_axis_tready;
        for (int j = NST - 2; j >= 0; j--)
            en[j] = !valid_reg[j] || en[j+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= s_axis_tvalid;
            for (int j = 1; j < NST; j++)
                if (en[j])
                    valid_reg[j] <= valid_reg[j-1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[NST-1];

    // ---------------- configuration
    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    // ---------------- stage 0: products
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;
    logic signed [15:0] qx_reg, qw_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            qx_reg <= qx;
            qw_reg <= qw;
        end
    end

    // ---------------- stage 1: pole test and q28 sums
    localparam logic signed [QW-1:0] ONE  = QW'(1) <<< INT_Q;
    localparam logic signed [QW-1:0] HALF = QW'(1) <<< (INT_Q - 1);

    logic signed [QW-1:0] k_next, diff_next, absd_next, tol_ext;
    logic signed [QW-1:0] bn_next, bd_next, hn_next, hd_next, s_next;
    logic signed [29:0]   s_clamp;
    logic [1:0]           pc_next;

    always_comb
    begin
        tol_ext   = QW'(tol_reg);
        // k = x*y + z*w
        k_next    = to_q28(QW'(xy_reg) + QW'(wz_reg));
        diff_next = k_next - HALF;
        absd_next = diff_next[QW-1] ? -diff_next : diff_next;
        if (absd_next < tol_ext)
            pc_next = PC_NORTH;
        else if (k_next + HALF < tol_ext)
            pc_next = PC_SOUTH;
        else
            pc_next = PC_GENERAL;

        bn_next = to_q28((QW'(wx_reg) + QW'(yz_reg)) <<< 1);
        bd_next = ONE - to_q28((QW'(xx_reg) + QW'(yy_reg)) <<< 1);
        hn_next = to_q28((QW'(wz_reg) + QW'(xy_reg)) <<< 1);
        hd_next = ONE - to_q28((QW'(yy_reg) + QW'(zz_reg)) <<< 1);
        s_next  = to_q28((QW'(wy_reg) - QW'(zx_reg)) <<< 1);
        if (s_next > ONE)
            s_clamp = 30'(ONE);
        else if (s_next < -ONE)
            s_clamp = 30'(-ONE);
        else
            s_clamp = 30'(s_next);
    end

    logic signed [QW-1:0] bn1_reg, bd1_reg, hy1_reg, hx1_reg;
    logic signed [29:0]   s1_reg;
    logic [1:0]           pc1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pc1_reg <= pc_next;
            bn1_reg <= bn_next;
            bd1_reg <= bd_next;
            // pole cases take atan2(x, w) on the raw components
            hy1_reg <= (pc_next == PC_GENERAL) ? hn_next : QW'(qx_reg);
            hx1_reg <= (pc_next == PC_GENERAL) ? hd_next : QW'(qw_reg);
            s1_reg  <= s_clamp;
        end
    end

    // ---------------- stage 2: 1 - s^2 as the square root operand
    logic [28:0]     s_mag;
    logic [SQ_W-1:0] s_sq;
    assign s_mag = s1_reg[29] ? 29'(-s1_reg) : 29'(s1_reg);
    assign s_sq  = SQ_W'(s_mag) * SQ_W'(s_mag);

    logic [SQ_W-1:0]      rem_reg  [SQ_STEPS+1];
    logic [SQ_W-1:0]      root_reg [SQ_STEPS+1];
    logic signed [QW-1:0] bn_d_reg [SQ_STEPS+1];
    logic signed [QW-1:0] bd_d_reg [SQ_STEPS+1];
    logic signed [QW-1:0] hy_d_reg [SQ_STEPS+1];
    logic signed [QW-1:0] hx_d_reg [SQ_STEPS+1];
    logic signed [29:0]   s_d_reg  [SQ_STEPS+1];
    logic [1:0]           pc_d_reg [SQ_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rem_reg[0]  <= (SQ_W'(1) << (2 * INT_Q)) - s_sq;
            root_reg[0] <= '0;
            bn_d_reg[0] <= bn1_reg;
            bd_d_reg[0] <= bd1_reg;
            hy_d_reg[0] <= hy1_reg;
            hx_d_reg[0] <= hx1_reg;
            s_d_reg[0]  <= s1_reg;
            pc_d_reg[0] <= pc1_reg;
        end
    end

    // ---------------- square root chain, one result bit per cell
    for (genvar t = 0; t < SQ_STEPS; t++)
    begin : g_sqrt
        q2e_sqrt_cell #(
            .STEP (SQ_STEPS - 1 - t)
        ) u_cell (
            .clk      (clk),
            .en       (en[ST_SQ+t]),
            .rem_in   (rem_reg[t]),
            .root_in  (root_reg[t]),
            .rem_out  (rem_reg[t+1]),
            .root_out (root_reg[t+1])
        );

        always_ff @(posedge clk)
        begin
            if (en[ST_SQ+t])
            begin
                bn_d_reg[t+1] <= bn_d_reg[t];
                bd_d_reg[t+1] <= bd_d_reg[t];
                hy_d_reg[t+1] <= hy_d_reg[t];
                hx_d_reg[t+1] <= hx_d_reg[t];
                s_d_reg[t+1]  <= s_d_reg[t];
                pc_d_reg[t+1] <= pc_d_reg[t];
            end
        end
    end

    // ---------------- quadrant fold for the three rotators
    rot_t pre_b, pre_h, pre_a;
    logic [28:0] cos_val;

    always_comb
    begin
        cos_val = root_reg[SQ_STEPS][28:0];
        pre_b   = prerot(CW'(bn_d_reg[SQ_STEPS]), CW'(bd_d_reg[SQ_STEPS]));
        pre_h   = prerot(CW'(hy_d_reg[SQ_STEPS]), CW'(hx_d_reg[SQ_STEPS]));
        pre_a   = prerot(CW'(s_d_reg[SQ_STEPS]), CW'({1'b0, cos_val}));
    end

    // rotator 0 bank, 1 heading, 2 attitude
    logic signed [CW-1:0]    cx_reg [3][CORDIC_STAGES+1];
    logic signed [CW-1:0]    cy_reg [3][CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] ca_reg [3][CORDIC_STAGES+1];
    logic [2:0]              zf_reg [CORDIC_STAGES+1];
    logic [1:0]              pcc_reg[CORDIC_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (en[ST_PRE])
        begin
            cx_reg[0][0] <= pre_b.x;
            cy_reg[0][0] <= pre_b.y;
            ca_reg[0][0] <= pre_b.ang;
            cx_reg[1][0] <= pre_h.x;
            cy_reg[1][0] <= pre_h.y;
            ca_reg[1][0] <= pre_h.ang;
            cx_reg[2][0] <= pre_a.x;
            cy_reg[2][0] <= pre_a.y;
            ca_reg[2][0] <= pre_a.ang;
            zf_reg[0]    <= {pre_a.zero, pre_h.zero, pre_b.zero};
            pcc_reg[0]   <= pc_d_reg[SQ_STEPS];
        end
    end

    // ---------------- cordic chain, one micro-rotation per cell
    for (genvar t = 0; t < CORDIC_STAGES; t++)
    begin : g_cordic
        for (genvar r = 0; r < 3; r++)
        begin : g_rot
            q2e_cordic_cell #(
                .DW    (CW),
                .SHIFT (t)
            ) u_cell (
                .clk     (clk),
                .en      (en[ST_COR+t]),
                .x_in    (cx_reg[r][t]),
                .y_in    (cy_reg[r][t]),
                .ang_in  (ca_reg[r][t]),
                .x_out   (cx_reg[r][t+1]),
                .y_out   (cy_reg[r][t+1]),
                .ang_out (ca_reg[r][t+1])
            );
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_COR+t])
            begin
                zf_reg[t+1]  <= zf_reg[t];
                pcc_reg[t+1] <= pcc_reg[t];
            end
        end
    end

    // ---------------- rounding, saturation and pole overrides
    logic signed [ANG_W+1:0] ang_b, ang_h, ang_a;
    logic [1:0]              pc_fin;
    logic signed [15:0]      bank_next, att_next, head_next;

    always_comb
    begin
        pc_fin = pcc_reg[CORDIC_STAGES];
        ang_b  = zf_reg[CORDIC_STAGES][0] ? '0 : (ANG_W+2)'(ca_reg[0][CORDIC_STAGES]);
        ang_h  = zf_reg[CORDIC_STAGES][1] ? '0 : (ANG_W+2)'(ca_reg[1][CORDIC_STAGES]);
        ang_a  = zf_reg[CORDIC_STAGES][2] ? '0 : (ANG_W+2)'(ca_reg[2][CORDIC_STAGES]);
        if (pc_fin == PC_NORTH)
        begin
            bank_next = '0;
            att_next  = 16'(HALF_PI_Q12);
            head_next = to_q12_sat(ang_h <<< 1, HEAD_MAX);
        end
        else if (pc_fin == PC_SOUTH)
        begin
            bank_next = '0;
            att_next  = -16'(HALF_PI_Q12);
            head_next = to_q12_sat(-(ang_h <<< 1), HEAD_MAX);
        end
        else
        begin
            bank_next = to_q12_sat(ang_b, BANK_MAX);
            att_next  = to_q12_sat(ang_a, ATT_MAX);
            head_next = to_q12_sat(ang_h, HEAD_MAX);
        end
    end

    logic [14:0] bank_reg;
    logic [13:0] att_reg;
    logic [15:0] head_reg;
    logic [1:0]  pc_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            bank_reg <= bank_next[14:0];
            att_reg  <= att_next[13:0];
            head_reg <= head_next;
            pc_reg   <= pc_fin;
        end
    end

    assign m_axis_tdata = {3'b000, head_reg, att_reg, bank_reg};
    assign m_axis_tuser = pc_reg;

endmodule
`default_nettype wire
